>>> rtl/core/sfb_pkg.sv
`default_nettype none

package sfb_pkg;

  typedef logic [7:0] byte_t;

  // Frame geometry
  localparam int FRAME_LEN = 7;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  typedef logic [IDX_W-1:0] idx_t;

  // Byte positions within the frame, in send order
  localparam idx_t IDX_START = idx_t'(0);
  localparam idx_t IDX_W0    = idx_t'(1);
  localparam idx_t IDX_W1    = idx_t'(2);
  localparam idx_t IDX_W2    = idx_t'(3);
  localparam idx_t IDX_W3    = idx_t'(4);
  localparam idx_t IDX_FLAGS = idx_t'(5);
  localparam idx_t IDX_CRC   = idx_t'(FRAME_LEN - 1);

  // Frame constants
  localparam byte_t START_BYTE = 8'h7E;
  localparam byte_t CRC_INIT   = 8'hFF;
  localparam byte_t CRC_POLY   = 8'h07;
  localparam byte_t CRC_TOP    = 8'h80;

  // Input beat layout: data_word, serviceable, permitted, zero pad
  localparam int S_DATA_W = 40;

  // CRC-8 update over one byte, MSB first
  function automatic byte_t crc8_byte(input byte_t crc, input byte_t b);
    byte_t r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((r & CRC_TOP) != 8'h00) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/status_frame_builder_crc8_core.sv
`default_nettype none

// Status frame builder with CRC-8.
// Slave side (s_*) takes one beat per frame: a 32-bit data word and the
// serviceable and permitted flags. Master side (m_*) sends the seven-byte
// frame one byte per beat: start byte 0x7E, data word LSB first, flags
// byte (serviceable bit 0, permitted bit 1), then the CRC-8 byte
// (poly 0x07, init 0xFF, MSB first), which is marked by m_tlast.
// The input beat goes through the holding register and then the frame
// serializer before the start byte is presented.
// Frames follow back to back when the next request is already held.
// The CRC is built up one byte per cycle while the receiver takes the
// bytes as they go out.
// One further input beat is held while a frame is being sent, so the
// input side is ready again as soon as the holding register is empty.
// When the receiver stalls, the current byte holds and s_tready drops
// once the holding register is full.
// Reset clears the holding register and the serializer; no frame survives.
module status_frame_builder_crc8_core (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [sfb_pkg::S_DATA_W-1:0]   s_tdata,   // [31:0] data_word, [32] serviceable,
                                                    // [33] permitted, [39:34] zero
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output sfb_pkg::byte_t                 m_tdata,   // [7:0] frame_byte
  output logic                           m_tlast    // last_byte
);
  import sfb_pkg::*;

  logic        pend_valid;
  logic [31:0] pend_word;
  logic [1:0]  pend_flags;
  logic        ld_ready;
  logic        s_beat;

  assign s_tready = !pend_valid || ld_ready;
  assign s_beat   = s_tvalid && s_tready;

  // Holding register between the input and the serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_beat) begin
      pend_valid <= 1'b1;
    end else if (ld_ready) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      pend_word  <= s_tdata[31:0];
      pend_flags <= {s_tdata[33], s_tdata[32]};
    end
  end

  sfb_frame_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (pend_valid),
    .load_ready (ld_ready),
    .load_word  (pend_word),
    .load_flags (pend_flags),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/core/sfb_frame_ser.sv
`default_nettype none

module sfb_frame_ser (
  input  wire              clk,
  input  wire              rst,
  // frame request from the holding register
  input  wire              load_valid,
  output logic             load_ready,
  input  wire  [31:0]      load_word,
  input  wire  [1:0]       load_flags,   // [0] serviceable, [1] permitted
  // byte stream out
  output logic             m_tvalid,
  input  wire              m_tready,
  output sfb_pkg::byte_t   m_tdata,      // [7:0] frame_byte
  output logic             m_tlast       // last_byte
);
  import sfb_pkg::*;

  logic        busy;
  idx_t        idx;
  logic [31:0] word;
  logic [1:0]  flags;
  byte_t       crc;

  byte_t cur_byte;
  logic  beat;
  logic  last_beat;

  // Byte select for the current position
  always_comb begin
    case (idx)
      IDX_START: cur_byte = START_BYTE;
      IDX_W0:    cur_byte = word[7:0];
      IDX_W1:    cur_byte = word[15:8];
      IDX_W2:    cur_byte = word[23:16];
      IDX_W3:    cur_byte = word[31:24];
      IDX_FLAGS: cur_byte = {6'b0, flags};
      default:   cur_byte = crc;
    endcase
  end

  assign m_tvalid   = busy;
  assign m_tdata    = cur_byte;
  assign m_tlast    = (idx == IDX_CRC);
  assign beat       = busy && m_tready;
  assign last_beat  = beat && m_tlast;
  assign load_ready = !busy || last_beat;

  // Control: busy flag and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_START;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      idx  <= IDX_START;
    end else if (last_beat) begin
      busy <= 1'b0;
      idx  <= IDX_START;
    end else if (beat) begin
      idx <= idx + idx_t'(1);
    end
  end

  // Payload and running CRC
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      word  <= load_word;
      flags <= load_flags;
      crc   <= CRC_INIT;
    end else if (beat && !m_tlast) begin
      crc <= crc8_byte(crc, cur_byte);
    end
  end

`ifndef SYNTHESIS
  // a frame always starts on the start byte with a fresh CRC
  a_start_crc: assert property (@(posedge clk) disable iff (rst)
    (busy && idx == IDX_START) |-> (crc == CRC_INIT && m_tdata == START_BYTE))
    else $error("frame start without fresh CRC");

  // position never runs past the CRC byte
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= IDX_CRC))
    else $error("byte position out of range");

  // after the last beat the next frame starts at position zero
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    last_beat |=> (idx == IDX_START))
    else $error("frame did not wrap to start");

  // a new frame is taken only when the previous one is done
  a_load: assert property (@(posedge clk) disable iff (rst)
    (load_valid && load_ready && busy) |-> last_beat)
    else $error("frame loaded over a running frame");
`endif

endmodule

`default_nettype wire

>>> dv/status_frame_builder_crc8_core_test.sv
`timescale 1ns / 1ps

module status_frame_builder_crc8_core_test;
  import sfb_pkg::*;

  localparam int HOLD_CYCLES     = 90;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_PHASES      = 4;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_PRINTS      = 30;

  // One directed frame request; flags_byte is the hand-typed flags byte when typed is set
  typedef struct {
    logic [31:0] word;
    logic        svc;
    logic        perm;
    logic        typed;
    byte_t       flags_byte;
  } status_req_t;

  // One expected output beat
  typedef struct packed {
    byte_t value;
    logic  last;
  } frame_beat_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tready = 1'b0;
  wire                 s_tready;
  wire                 m_tvalid;
  byte_t               m_tdata;
  wire                 m_tlast;

  frame_beat_t frame_bytes_due[$];
  int          errors        = 0;
  int          frames_sent   = 0;
  int          bytes_checked = 0;
  int          idle_pct      = 0;
  int          stall_pct     = 0;
  bit          hold_start    = 1'b0;

  // Directed frames: field extremes, all flag combinations, start-byte lookalikes
  status_req_t status_reqs [13] = '{
    '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 8'h00},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'h03},
    '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 8'h01},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 8'h02},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 8'h00},
    '{32'h7E7E_7E7E, 1'b1, 1'b0, 1'b0, 8'h00},
    '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 8'h00},
    '{32'h8000_0000, 1'b1, 1'b1, 1'b0, 8'h00},
    '{32'h0000_00FF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{32'hFF00_0000, 1'b1, 1'b0, 1'b0, 8'h00},
    '{32'hA5A5_A5A5, 1'b0, 1'b1, 1'b0, 8'h00},
    '{32'h5A5A_5A5A, 1'b1, 1'b1, 1'b0, 8'h00},
    '{32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  status_frame_builder_crc8_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("timeout: %0d frame bytes still outstanding", frame_bytes_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // CRC-8, poly 0x07, MSB first, one bit per step
  function automatic byte_t crc8_next(input byte_t acc, input byte_t b);
    byte_t r;
    r = acc ^ b;
    repeat (8) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Build the seven expected beats of one status frame
  function automatic void predict_frame(input logic [31:0] word, input logic svc,
                                        input logic perm);
    byte_t frame [FRAME_LEN];
    byte_t crc;
    frame[0] = START_BYTE;
    frame[1] = word[7:0];
    frame[2] = word[15:8];
    frame[3] = word[23:16];
    frame[4] = word[31:24];
    frame[5] = {6'b0, perm, svc};
    crc = CRC_INIT;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      crc = crc8_next(crc, frame[i]);
    end
    frame[FRAME_LEN-1] = crc;
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame_bytes_due.push_back('{frame[i], (i == FRAME_LEN - 1)});
    end
  endfunction

  // Random words lean on the edges now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat from a falling edge, optionally after random gaps; returns at a falling edge
  task automatic send_status(input logic [31:0] word, input logic svc, input logic perm);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - 34){1'b0}}, perm, svc, word};
    do @(posedge clk); while (!s_tready);
    predict_frame(word, svc, perm);
    frames_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output checker
  always @(posedge clk) begin : frame_check
    frame_beat_t due;
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h last=%b", m_tdata, m_tlast));
      end else begin
        due = frame_bytes_due.pop_front();
        if (m_tdata !== due.value) begin
          report_mismatch($sformatf("frame byte %02h, expected %02h", m_tdata, due.value));
        end
        if (m_tlast !== due.last) begin
          report_mismatch($sformatf("tlast %b, expected %b (byte %02h)",
                                    m_tlast, due.last, due.value));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int directed_frames;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames, no idling; typed flags byte replaces the predicted one
    foreach (status_reqs[i]) begin
      send_status(status_reqs[i].word, status_reqs[i].svc, status_reqs[i].perm);
      if (status_reqs[i].typed) begin
        frame_bytes_due[frame_bytes_due.size() - 2].value = status_reqs[i].flags_byte;
      end
    end
    directed_frames = frames_sent;

    // Random frames: free flow (with a long receiver hold-off), slow sender,
    // slow receiver, light idling on both sides
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_start = 1'b1; end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_status(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    s_tvalid  <= 1'b0;
    stall_pct = 0;

    wait (frame_bytes_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never arrived", frame_bytes_due.size()));
    end

    $display("sent %0d status frames (%0d directed, rest random under four idle/stall mixes",
             frames_sent, directed_frames);
    $display("and one long receiver hold-off); checked %0d frame bytes, %0d mismatches",
             bytes_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> status_frame_builder_crc8_core.f
rtl/core/sfb_pkg.sv
rtl/core/sfb_frame_ser.sv
rtl/core/status_frame_builder_crc8_core.sv
dv/status_frame_builder_crc8_core_test.sv
